/* src/rrt_tree_nearest_vertex_assert.svh */
// Assertion macros shared by the tree store modules.
`ifndef RRT_TREE_NEAREST_VERTEX_ASSERT_SVH
`define RRT_TREE_NEAREST_VERTEX_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTNV_ASSERT_IMP(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTNV_ASSERT_NXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

/* src/rtnv_pkg.sv */
package rtnv_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_NEAREST = 2'd2,
    OP_LAST    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_RESULT
  } ctl_state_t;

  // Source of the vertex memory read address.
  typedef enum logic [1:0] {
    RD_PARENT,
    RD_SCAN,
    RD_RESULT
  } rd_sel_t;

  // Cycles from the last scan read until the best match is settled.
  localparam int unsigned DRAIN_CYCLES = 3;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         parent_index;
    logic               has_parent;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         vertex_index;
    logic [7:0]         vertex_depth;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [8:0]         vertex_count;
  } res_t;

  typedef struct packed {
    logic    req_load;
    logic    clear_count;
    logic    out_zero;
    status_t zero_status;
    rd_sel_t rd_sel;
    logic    scan_start;
    logic    scan_issue;
    logic    add_write;
    logic    out_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
  } dp_stat_t;

endpackage

/* src/rrt_tree_nearest_vertex.sv */
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | start, busy, in_req      | taken at a clock edge with start && !busy
// result    | out_strobe, out_res      | valid for the single cycle out_strobe is high
//
// Clear never raises busy. Add holds busy through S_ADD_RD and S_ADD_WR, last
// through S_FETCH and S_RESULT; nearest through S_SCAN, S_DRAIN, S_FETCH and
// S_RESULT, the scan reading one vertex per cycle through the single memory read port.
// Each result appears the cycle after its request finishes, and a new request
// may be taken in that same cycle. Reset (rst_n low, synchronous) empties the
// tree; vertex memories are not cleared. The receiver cannot stall results.
module rrt_tree_nearest_vertex #(
  parameter int TREE_CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rtnv_pkg::req_t in_req,
  output logic           out_strobe,
  output rtnv_pkg::res_t out_res
);
  import rtnv_pkg::*;

  // The controller sequences each request; the datapath holds the vertex
  // memories, the vertex count, the distance pipeline and the result register.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtnv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_req.op),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // A nearest search compares squared distances, which orders the vertices
  // the same way as true distances; on equal distances the lower index wins
  // because only a strictly smaller distance replaces the running best.
  rtnv_dp #(
    .TREE_CAPACITY (TREE_CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule

/* src/rtnv_ctrl.sv */
`include "rrt_tree_nearest_vertex_assert.svh"

module rtnv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rtnv_pkg::op_t     in_op,
  input  rtnv_pkg::dp_stat_t stat,
  output logic              busy,
  output logic              out_strobe,
  output rtnv_pkg::dp_cmd_t cmd
);
  import rtnv_pkg::*;

  localparam int DW = $clog2(DRAIN_CYCLES + 1);

  ctl_state_t    state_r, state_nxt;
  logic [DW-1:0] drain_cnt_r, drain_cnt_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic          accept;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && (state_r == S_IDLE);
  assign out_strobe = out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      drain_cnt_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      drain_cnt_r  <= drain_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    drain_cnt_nxt   = drain_cnt_r;
    cmd             = '0;
    cmd.zero_status = ST_OK;
    cmd.rd_sel      = RD_SCAN;
    cmd.req_load    = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              cmd.clear_count = 1'b1;
              cmd.out_zero    = 1'b1;
            end
            OP_ADD: begin
              if (stat.full) begin
                cmd.out_zero    = 1'b1;
                cmd.zero_status = ST_FULL;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end
            OP_NEAREST: begin
              if (stat.empty) begin
                cmd.out_zero    = 1'b1;
                cmd.zero_status = ST_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.out_zero    = 1'b1;
                cmd.zero_status = ST_EMPTY;
              end else begin
                state_nxt = S_FETCH;
              end
            end
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.rd_sel = RD_PARENT;
        state_nxt  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          drain_cnt_nxt = '0;
          state_nxt     = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_cnt_nxt = drain_cnt_r + DW'(1);
        if (drain_cnt_r == DW'(DRAIN_CYCLES - 1)) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_sel = RD_RESULT;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        cmd.out_hit = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_strobe_nxt = cmd.out_zero || cmd.add_write || cmd.out_hit;
  end

  `RTNV_ASSERT_NXT(a_done_strobe, clk, rst_n, (state_r == S_ADD_WR || state_r == S_RESULT), (out_strobe_r && state_r == S_IDLE))
  `RTNV_ASSERT_NXT(a_scan_holds, clk, rst_n, (state_r == S_SCAN && !stat.scan_last), (state_r == S_SCAN))
  `RTNV_ASSERT_IMP(a_drain_bound, clk, rst_n, (state_r == S_DRAIN), (drain_cnt_r < DW'(DRAIN_CYCLES)))

endmodule

/* src/rtnv_dp.sv */
`include "rrt_tree_nearest_vertex_assert.svh"

module rtnv_dp #(
  parameter int TREE_CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtnv_pkg::req_t     in_req,
  input  rtnv_pkg::dp_cmd_t  cmd,
  output rtnv_pkg::dp_stat_t stat,
  output rtnv_pkg::res_t     out_res
);
  import rtnv_pkg::*;

  localparam int IW = $clog2(TREE_CAPACITY);
  localparam int CW = $clog2(TREE_CAPACITY + 1);
  localparam int PW = (IW > 8) ? IW : 8;
  localparam int MW = (CW > 8) ? CW : 8;
  localparam int QW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] CNT_MAX = CW'(TREE_CAPACITY);

  logic [15:0] x_mem [TREE_CAPACITY];
  logic [15:0] y_mem [TREE_CAPACITY];
  logic [7:0]  d_mem [TREE_CAPACITY];

  req_t          req_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic [IW-1:0] res_idx_r;
  logic [15:0]   x_rd_r, y_rd_r;
  logic [7:0]    d_rd_r;

  logic                s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IW-1:0]       s1_idx_r, s2_idx_r, s3_idx_r;
  logic signed [16:0]  dx_r, dy_r;
  logic [31:0]         sqx_r, sqy_r;
  logic [32:0]         best_d_r;
  logic [IW-1:0]       best_idx_r;
  res_t                res_r, res_nxt;

  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      res_addr;
  logic [PW-1:0]      par_ext;
  logic               par_ok;
  logic [7:0]         new_depth;
  logic signed [16:0] dx_nxt, dy_nxt;
  logic signed [33:0] sqx_full, sqy_full;
  logic [32:0]        dist_sq;
  logic [PW-1:0]      slot_ix, res_ix;
  logic [QW-1:0]      cnt_q, cnt_inc_q, cnt_hold_q;

  assign cnt_m1         = count_r - CW'(1);
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_MAX);
  assign stat.scan_last = (CW'(scan_idx_r) == cnt_m1);

  assign par_ext  = PW'(req_r.parent_index);
  assign par_ok   = req_r.has_parent && (MW'(req_r.parent_index) < MW'(count_r));
  assign res_addr = (req_r.op == OP_LAST) ? cnt_m1[IW-1:0] : best_idx_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_PARENT: rd_addr = par_ext[IW-1:0];
      RD_RESULT: rd_addr = res_addr;
      default:   rd_addr = scan_idx_r;
    endcase
  end

  // Vertex memories: one write port for add, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      x_mem[count_r[IW-1:0]] <= req_r.pos_x;
      y_mem[count_r[IW-1:0]] <= req_r.pos_y;
      d_mem[count_r[IW-1:0]] <= new_depth;
    end
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
    d_rd_r <= d_mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_count) begin
      count_nxt = '0;
    end else if (cmd.add_write) begin
      count_nxt = count_r + CW'(1);
    end
    scan_idx_nxt = scan_idx_r;
    if (cmd.scan_start) begin
      scan_idx_nxt = '0;
    end else if (cmd.scan_issue) begin
      scan_idx_nxt = scan_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      scan_idx_r <= scan_idx_nxt;
      s1_vld_r   <= cmd.scan_issue;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
    end
  end

  // Distance pipeline: difference, square, then sum and compare.
  assign dx_nxt   = $signed({x_rd_r[15], x_rd_r}) - $signed({req_r.pos_x[15], req_r.pos_x});
  assign dy_nxt   = $signed({y_rd_r[15], y_rd_r}) - $signed({req_r.pos_y[15], req_r.pos_y});
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign dist_sq  = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_req;
    end
    if (cmd.rd_sel == RD_RESULT) begin
      res_idx_r <= res_addr;
    end
    s1_idx_r <= scan_idx_r;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sqx_r    <= sqx_full[31:0];
    sqy_r    <= sqy_full[31:0];
    if (s3_vld_r && ((s3_idx_r == '0) || (dist_sq < best_d_r))) begin
      best_d_r   <= dist_sq;
      best_idx_r <= s3_idx_r;
    end
    res_r <= res_nxt;
  end

  always_comb begin
    if (!par_ok) begin
      new_depth = 8'd0;
    end else if (d_rd_r == 8'hFF) begin
      new_depth = 8'hFF;
    end else begin
      new_depth = d_rd_r + 8'd1;
    end
  end

  assign slot_ix    = PW'(count_r[IW-1:0]);
  assign res_ix     = PW'(res_idx_r);
  assign cnt_q      = cmd.clear_count ? '0 : QW'(count_r);
  assign cnt_inc_q  = QW'(count_r + CW'(1));
  assign cnt_hold_q = QW'(count_r);

  always_comb begin
    res_nxt = res_r;
    if (cmd.out_zero) begin
      res_nxt              = '0;
      res_nxt.status       = cmd.zero_status;
      res_nxt.vertex_count = cnt_q[8:0];
    end else if (cmd.add_write) begin
      res_nxt.status       = ST_OK;
      res_nxt.vertex_index = slot_ix[7:0];
      res_nxt.vertex_depth = new_depth;
      res_nxt.vertex_x     = req_r.pos_x;
      res_nxt.vertex_y     = req_r.pos_y;
      res_nxt.vertex_count = cnt_inc_q[8:0];
    end else if (cmd.out_hit) begin
      res_nxt.status       = ST_OK;
      res_nxt.vertex_index = res_ix[7:0];
      res_nxt.vertex_depth = d_rd_r;
      res_nxt.vertex_x     = x_rd_r;
      res_nxt.vertex_y     = y_rd_r;
      res_nxt.vertex_count = cnt_hold_q[8:0];
    end
  end

  assign out_res = res_r;

  `RTNV_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, (count_r <= CNT_MAX))
  `RTNV_ASSERT_IMP(a_no_overflow, clk, rst_n, cmd.add_write, !stat.full)

endmodule
